FILE: rtl/core/dbil_pkg.sv
// ----------------------------------------------------------------------------
// dbil_pkg: shared types and constants of the boot image loader
// Result kinds, queue entry layout and default sizes used by all modules.
// ----------------------------------------------------------------------------
package dbil_pkg;

  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  // One parser step: an optional memory write followed by a final result
  typedef struct packed {
    logic              has_wr;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    kind_e             fin_kind;
    logic [ADDR_W-1:0] fin_addr;
    logic [DATA_W-1:0] fin_start;
  } q_entry_t;

  // Queue status seen by the back end and the core's input stall
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/core/dbil_front.sv
// ----------------------------------------------------------------------------
// dbil_front: boot image parser
// Accepts start and ROM data transactions, steps the parser state and
// pushes one queue entry per transaction that produces results.
// ----------------------------------------------------------------------------
module dbil_front import dbil_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  input  logic              accept_i,
  input  logic              operation_i,
  input  logic [DATA_W-1:0] rom_data_i,
  output logic              push_o,
  output q_entry_t          entry_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_WIDTH, PH_CONTROL, PH_LENGTH, PH_OFFSET, PH_DATA, PH_DONE
  } phase_e;

  localparam logic [DATA_W-1:0] WIDTH_8  = DATA_W'(8);
  localparam logic [DATA_W-1:0] WIDTH_16 = DATA_W'(16);
  localparam logic [DATA_W-1:0] WIDTH_32 = DATA_W'(32);

  phase_e            phase_q, phase_d;
  logic [ADDR_W-1:0] rom_base_q;
  logic [ADDR_W-1:0] rp_q, rp_d;
  logic [1:0]        sel_q, sel_d;
  logic [1:0]        pi_q, pi_d;
  logic [DATA_W-1:0] asm_q, asm_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [ADDR_W-1:0] dest_q, dest_d;
  logic [DATA_W-1:0] entry_q, entry_d;
  logic              first_q, first_d;

  logic [2:0]        adv;
  logic [1:0]        pi_next;
  logic [4:0]        shift;
  logic [DATA_W-1:0] asm_new;

  // Pieces per 32-bit word and piece shift for the current ROM width
  always_comb begin
    case (sel_q)
      2'd0:    adv = 3'd4;
      2'd1:    adv = 3'd2;
      default: adv = 3'd1;
    endcase
    case (sel_q)
      2'd0:    shift = {pi_q, 3'b000};
      2'd1:    shift = {pi_q[0], 4'b0000};
      default: shift = 5'd0;
    endcase
    pi_next = pi_q + 2'd1;
    asm_new = (pi_q == 2'd0) ? rom_data_i : (asm_q | (rom_data_i << shift));
  end

  // Parser step
  always_comb begin
    phase_d = phase_q;
    rp_d    = rp_q;
    sel_d   = sel_q;
    pi_d    = pi_q;
    asm_d   = asm_q;
    rem_d   = rem_q;
    dest_d  = dest_q;
    entry_d = entry_q;
    first_d = first_q;
    push_o  = 1'b0;
    entry_o = '{has_wr: 1'b0, wr_addr: '0, wr_data: '0,
                fin_kind: KIND_READ, fin_addr: '0, fin_start: '0};

    if (accept_i) begin
      if (operation_i == OP_START) begin
        phase_d = PH_WIDTH;
        rp_d    = rom_base_q;
        sel_d   = 2'd0;
        pi_d    = 2'd0;
        asm_d   = '0;
        rem_d   = '0;
        dest_d  = '0;
        entry_d = '0;
        first_d = 1'b1;
        push_o  = 1'b1;
        entry_o.fin_addr = rom_base_q;
      end else begin
        case (phase_q)
          PH_WIDTH: begin
            push_o = 1'b1;
            if (rom_data_i == WIDTH_8 || rom_data_i == WIDTH_16 ||
                rom_data_i == WIDTH_32) begin
              if (rom_data_i == WIDTH_8) begin
                sel_d = 2'd0;
                rp_d  = rp_q + ADDR_W'(4);
              end else if (rom_data_i == WIDTH_16) begin
                sel_d = 2'd1;
                rp_d  = rp_q + ADDR_W'(2);
              end else begin
                sel_d = 2'd2;
                rp_d  = rp_q + ADDR_W'(1);
              end
              pi_d    = 2'd0;
              phase_d = PH_CONTROL;
              entry_o.fin_addr = rp_d;
            end else begin
              phase_d = PH_DONE;
              entry_o.fin_kind = KIND_DONE;
            end
          end
          PH_CONTROL, PH_LENGTH, PH_OFFSET, PH_DATA: begin
            push_o = 1'b1;
            asm_d  = asm_new;
            rp_d   = rp_q + ADDR_W'(1);
            entry_o.fin_addr = rp_d;
            if ({1'b0, pi_next} < adv && pi_next != 2'd0) begin
              pi_d = pi_next;
            end else begin
              pi_d = 2'd0;
              case (phase_q)
                PH_CONTROL: phase_d = PH_LENGTH;
                PH_LENGTH: begin
                  if (asm_new == '0) begin
                    phase_d = PH_DONE;
                    entry_o.fin_kind  = KIND_DONE;
                    entry_o.fin_addr  = '0;
                    entry_o.fin_start = entry_q;
                  end else begin
                    rem_d   = asm_new;
                    phase_d = PH_OFFSET;
                  end
                end
                PH_OFFSET: begin
                  dest_d = asm_new[ADDR_W-1:0];
                  if (first_q) begin
                    entry_d = asm_new;
                    first_d = 1'b0;
                  end
                  phase_d = PH_DATA;
                end
                default: begin
                  // data word: memory write, then the next read
                  entry_o.has_wr  = 1'b1;
                  entry_o.wr_addr = dest_q;
                  entry_o.wr_data = asm_new;
                  dest_d = dest_q + ADDR_W'(1);
                  rem_d  = rem_q - DATA_W'(1);
                  if (rem_d == '0) phase_d = PH_LENGTH;
                end
              endcase
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Parser state and configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      rom_base_q <= '0;
      rp_q       <= '0;
      sel_q      <= 2'd0;
      pi_q       <= 2'd0;
      asm_q      <= '0;
      rem_q      <= '0;
      dest_q     <= '0;
      entry_q    <= '0;
      first_q    <= 1'b1;
    end else begin
      if (cfg_we_i) rom_base_q <= cfg_wdata_i;
      phase_q <= phase_d;
      rp_q    <= rp_d;
      sel_q   <= sel_d;
      pi_q    <= pi_d;
      asm_q   <= asm_d;
      rem_q   <= rem_d;
      dest_q  <= dest_d;
      entry_q <= entry_d;
      first_q <= first_d;
    end
  end

endmodule

FILE: rtl/core/dbil_queue.sv
// ----------------------------------------------------------------------------
// dbil_queue: step queue between parser and result serializer
// Small FIFO of parser steps; lets either side stall on its own.
// ----------------------------------------------------------------------------
module dbil_queue import dbil_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_entry_t  entry_i,
  input  logic      pop_i,
  output q_entry_t  head_o,
  output q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_entry_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!status_o.full || pop_i)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty) else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/core/dbil_back.sv
// ----------------------------------------------------------------------------
// dbil_back: result serializer
// Pops parser steps and presents their results one per transaction in an
// output register: the memory write first, then the final result.
// ----------------------------------------------------------------------------
module dbil_back import dbil_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  q_entry_t          head_i,
  input  q_status_t         status_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [ADDR_W-1:0] address_o,
  output logic [DATA_W-1:0] write_data_o,
  output logic [DATA_W-1:0] start_address_o,
  output logic              last_o
);

  logic              valid_q;
  logic              pend_q;
  kind_e             kind_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;
  logic [DATA_W-1:0] start_q;
  logic              last_q;
  kind_e             pkind_q;
  logic [ADDR_W-1:0] paddr_q;
  logic [DATA_W-1:0] pstart_q;
  logic              load;

  // Output register free or being taken
  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && !pend_q && !status_i.empty;

  // Control: output valid and pending final result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else if (!status_i.empty) begin
        valid_q <= 1'b1;
        pend_q  <= head_i.has_wr;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  // Payload of the output register and the held final result
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        kind_q  <= pkind_q;
        addr_q  <= paddr_q;
        wdata_q <= '0;
        start_q <= pstart_q;
        last_q  <= 1'b1;
      end else if (head_i.has_wr) begin
        kind_q   <= KIND_WRITE;
        addr_q   <= head_i.wr_addr;
        wdata_q  <= head_i.wr_data;
        start_q  <= '0;
        last_q   <= 1'b0;
        pkind_q  <= head_i.fin_kind;
        paddr_q  <= head_i.fin_addr;
        pstart_q <= head_i.fin_start;
      end else begin
        kind_q  <= head_i.fin_kind;
        addr_q  <= head_i.fin_addr;
        wdata_q <= '0;
        start_q <= head_i.fin_start;
        last_q  <= 1'b1;
      end
    end
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = kind_q;
  assign address_o       = addr_q;
  assign write_data_o    = wdata_q;
  assign start_address_o = start_q;
  assign last_o          = last_q;

`ifndef ASSERT_OFF
  a_pend_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> valid_q) else $error("pending result without output");
  a_write_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KIND_WRITE) |-> (!last_q && pend_q))
    else $error("memory write not followed by final result");
`endif

endmodule

FILE: rtl/core/dsp_boot_image_loader_core.sv
// ----------------------------------------------------------------------------
// dsp_boot_image_loader_core: boot image loader, bus master side
// Parses a boot image read from ROM and issues memory writes for it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): operation_i = 0 starts a boot,
//   operation_i = 1 returns the ROM word in rom_data_i for the last read.
//   Output channel (out_valid_o / out_stall_i): one result per transaction,
//   kind_o = read request, memory write or boot done. last_o marks the
//   final result of an input transaction.
//   cfg_we_i / cfg_wdata_i write the ROM base address while idle.
// Timing:
//   An input transaction is parsed and queued at its accept edge; its first
//   result enters the output register once that register is free or being
//   taken. One input is taken per cycle while the queue has room; a data
//   word in mid-section yields two results, so the output port lags a run
//   of such inputs. The step queue (QueueDepth entries) absorbs this.
// Reset and stall:
//   Reset empties the queue and the output register and sets the parser
//   idle with base address 0. A stalled output holds its result; once the
//   queue fills, in_stall_o rises until an entry drains.
// ----------------------------------------------------------------------------
module dsp_boot_image_loader_core import dbil_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [DATA_W-1:0] rom_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [ADDR_W-1:0] address_o,
  output logic [DATA_W-1:0] write_data_o,
  output logic [DATA_W-1:0] start_address_o,
  output logic              last_o
);

  q_status_t status;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      pop;
  logic      accept;

  // Input transaction taken while the queue has room
  assign in_stall_o = status.full;
  assign accept     = in_valid_i && !status.full;

  dbil_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .operation_i (operation_i),
    .rom_data_i  (rom_data_i),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  dbil_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  dbil_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .status_i        (status),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .address_o       (address_o),
    .write_data_o    (write_data_o),
    .start_address_o (start_address_o),
    .last_o          (last_o)
  );

endmodule

FILE: tb/sv/dsp_boot_image_loader_core_tb.sv
// ----------------------------------------------------------------------------
// dsp_boot_image_loader_core_tb: self-checking bench for the boot image loader
// Feeds start and ROM word transactions through a valid/stall driver. A
// parser model inside the bench predicts every read request, memory write
// and boot done result, and a monitor compares the DUT output against it.
// Covers directed corner cases, then well-formed, truncated and junk boot
// images at several ROM base settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module dsp_boot_image_loader_core_tb;
  import dbil_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 450;

  // Parser phases of the bench model
  typedef enum logic [2:0] {
    P_IDLE, P_WIDTH, P_CONTROL, P_LENGTH, P_OFFSET, P_DATA, P_DONE
  } parse_phase_e;

  typedef struct {
    logic              op;
    logic [DATA_W-1:0] word;
  } rom_item_t;

  typedef struct {
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] start;
    logic              last;
  } loader_result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              operation_i = OP_START;
  logic [DATA_W-1:0] rom_data_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        kind_o;
  logic [ADDR_W-1:0] address_o;
  logic [DATA_W-1:0] write_data_o;
  logic [DATA_W-1:0] start_address_o;
  logic              last_o;

  dsp_boot_image_loader_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .rom_data_i      (rom_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .address_o       (address_o),
    .write_data_o    (write_data_o),
    .start_address_o (start_address_o),
    .last_o          (last_o)
  );

  // Clock, period 2
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rom_item_t      pending_items[$];
  rom_item_t      staged_items[$];
  loader_result_t expected_results[$];

  // Parser model state
  parse_phase_e      phase_m;
  logic [ADDR_W-1:0] rom_base_m;
  logic [DATA_W-1:0] read_ptr_m;
  logic [1:0]        width_sel_m;
  logic [1:0]        piece_idx_m;
  logic [DATA_W-1:0] word_acc_m;
  logic [DATA_W-1:0] words_left_m;
  logic [DATA_W-1:0] dest_ptr_m;
  logic [DATA_W-1:0] entry_m;
  logic              first_sec_m;

  int unsigned fail_count  = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_ignored   = 0;
  int unsigned n_reads     = 0;
  int unsigned n_writes    = 0;
  int unsigned n_dones     = 0;
  int unsigned n_random    = 0;
  int unsigned gen_width   = 32;

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  task automatic push_result(input kind_e kind, input logic [DATA_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata,
                             input logic [DATA_W-1:0] start, input logic last);
    loader_result_t r;
    r.kind  = kind;
    r.addr  = addr[ADDR_W-1:0];
    r.wdata = wdata;
    r.start = start;
    r.last  = last;
    expected_results.push_back(r);
  endtask

  task automatic push_read_request();
    push_result(KIND_READ, read_ptr_m, '0, '0, 1'b1);
  endtask

  task automatic loader_step(input logic op, input logic [DATA_W-1:0] word);
    int unsigned per_word;
    int unsigned sh;
    // Start restarts the parser in any phase
    if (op == OP_START) begin
      phase_m      = P_WIDTH;
      read_ptr_m   = {{(DATA_W-ADDR_W){1'b0}}, rom_base_m};
      width_sel_m  = '0;
      piece_idx_m  = '0;
      word_acc_m   = '0;
      words_left_m = '0;
      dest_ptr_m   = '0;
      entry_m      = '0;
      first_sec_m  = 1'b1;
      push_read_request();
      return;
    end
    if (phase_m == P_IDLE || phase_m == P_DONE) return;

    // Width word: pick piece size, skip the rest of its slots
    if (phase_m == P_WIDTH) begin
      if (word == 32'd8) width_sel_m = 2'd0;
      else if (word == 32'd16) width_sel_m = 2'd1;
      else if (word == 32'd32) width_sel_m = 2'd2;
      else begin
        phase_m = P_DONE;
        push_result(KIND_DONE, '0, '0, '0, 1'b1);
        return;
      end
      read_ptr_m  = read_ptr_m + (4 >> width_sel_m);
      piece_idx_m = '0;
      phase_m     = P_CONTROL;
      push_read_request();
      return;
    end

    // Assemble one 32-bit word from pieces, ORed in without masking
    per_word = 4 >> width_sel_m;
    if (piece_idx_m == 0) begin
      word_acc_m = word;
    end else begin
      sh = ((8 << width_sel_m) * piece_idx_m) & 31;
      word_acc_m = word_acc_m | (word << sh);
    end
    read_ptr_m  = read_ptr_m + 1;
    piece_idx_m = piece_idx_m + 2'd1;
    if (piece_idx_m != 0 && piece_idx_m < per_word) begin
      push_read_request();
      return;
    end
    piece_idx_m = '0;

    case (phase_m)
      P_CONTROL: begin
        phase_m = P_LENGTH;
        push_read_request();
      end
      P_LENGTH: begin
        if (word_acc_m == 0) begin
          phase_m = P_DONE;
          push_result(KIND_DONE, '0, '0, entry_m, 1'b1);
        end else begin
          words_left_m = word_acc_m;
          phase_m      = P_OFFSET;
          push_read_request();
        end
      end
      P_OFFSET: begin
        dest_ptr_m = word_acc_m;
        if (first_sec_m) begin
          entry_m     = word_acc_m;
          first_sec_m = 1'b0;
        end
        phase_m = P_DATA;
        push_read_request();
      end
      default: begin
        push_result(KIND_WRITE, dest_ptr_m, word_acc_m, '0, 1'b0);
        dest_ptr_m   = dest_ptr_m + 1;
        words_left_m = words_left_m - 1;
        if (words_left_m == 0) phase_m = P_LENGTH;
        push_read_request();
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic stage(input logic op, input logic [DATA_W-1:0] word);
    rom_item_t it;
    it.op   = op;
    it.word = word;
    staged_items.push_back(it);
  endtask

  // One 32-bit image word split into ROM pieces; noisy pieces are random
  task automatic stage_word(input logic [DATA_W-1:0] w, input bit noisy);
    int unsigned n;
    logic [DATA_W-1:0] piece;
    n = 32 / gen_width;
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy) begin
        piece = $urandom;
      end else begin
        piece = w >> (gen_width * i);
        if (gen_width < 32) piece = piece & ((32'd1 << gen_width) - 1);
      end
      stage(OP_DATA, piece);
    end
  endtask

  task automatic build_image(input int unsigned width, input int unsigned nsec);
    int unsigned len;
    logic [DATA_W-1:0] dest;
    staged_items.delete();
    gen_width = width;
    stage(OP_START, $urandom);
    stage(OP_DATA, width);
    stage_word($urandom, 1'b1);
    for (int unsigned s = 0; s < nsec; s++) begin
      len = $urandom_range(1, 3);
      stage_word(len, $urandom_range(0, 19) == 0);
      case ($urandom_range(0, 3))
        0:       dest = 32'hFFFF_FFFE;
        1:       dest = 32'h00FF_FFFE;
        default: dest = $urandom;
      endcase
      stage_word(dest, $urandom_range(0, 3) == 0);
      for (int unsigned d = 0; d < len; d++) stage_word($urandom, 1'b1);
    end
    stage_word('0, 1'b0);
  endtask

  task automatic commit_staged(input int unsigned count);
    for (int unsigned i = 0; i < count && i < staged_items.size(); i++)
      pending_items.push_back(staged_items[i]);
    n_random += count;
  endtask

  task automatic wait_drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_rom_base(input logic [ADDR_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rom_base_m  = v;
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned r;
    int unsigned w;
    int unsigned goal;
    goal = n_random + quota;
    while (n_random < goal) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0:       w = 8;
        1:       w = 16;
        default: w = 32;
      endcase
      build_image(w, $urandom_range(0, 3));
      if (r < 70) begin
        // complete image, sometimes trailed by words that are ignored
        if ($urandom_range(0, 4) == 0) stage(OP_DATA, $urandom);
        commit_staged(staged_items.size());
      end else if (r < 85) begin
        // truncated image, the next start cuts it off
        commit_staged($urandom_range(1, staged_items.size() - 1));
      end else begin
        // junk: random width word and stray data
        staged_items.delete();
        stage(OP_START, $urandom);
        stage(OP_DATA, (r < 92) ? $urandom : ($urandom & 32'h3F));
        for (int unsigned i = $urandom_range(0, 3); i > 0; i--) stage(OP_DATA, $urandom);
        commit_staged(staged_items.size());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: accepts, predicts, then presents the next transaction
  // ---------------------------------------------------------------------------
  int unsigned in_gap  = 0;
  bit          in_calm = 1'b0;

  always @(posedge clk_i) begin
    rom_item_t it;
    int unsigned before_n;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        before_n = expected_results.size();
        loader_step(operation_i, rom_data_i);
        n_accepted++;
        if (expected_results.size() == before_n) n_ignored++;
      end
      if ($urandom_range(0, 149) == 0) in_calm = !in_calm;
      if (!(in_valid_i && in_stall_o)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          it = pending_items.pop_front();
          operation_i <= it.op;
          rom_data_i  <= it.word;
          in_valid_i  <= 1'b1;
          in_gap = pick_gap(in_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor and stall generator
  // ---------------------------------------------------------------------------
  int unsigned out_stall_left = 0;
  bit          out_calm       = 1'b0;

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    loader_result_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transaction: kind 0x%0h address 0x%0h", kind_o, address_o);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("kind", DATA_W'(e.kind), DATA_W'(kind_o));
          check_field("address", DATA_W'(e.addr), DATA_W'(address_o));
          check_field("write_data", e.wdata, write_data_o);
          check_field("start_address", e.start, start_address_o);
          check_field("last", DATA_W'(e.last), DATA_W'(last_o));
          case (e.kind)
            KIND_READ:  n_reads++;
            KIND_WRITE: n_writes++;
            default:    n_dones++;
          endcase
        end
      end
      if ($urandom_range(0, 149) == 0) out_calm = !out_calm;
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_left = pick_gap(out_calm);
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    phase_m      = P_IDLE;
    rom_base_m   = '0;
    read_ptr_m   = '0;
    width_sel_m  = '0;
    piece_idx_m  = '0;
    word_acc_m   = '0;
    words_left_m = '0;
    dest_ptr_m   = '0;
    entry_m      = '0;
    first_sec_m  = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: ROM address wraps in its low 24 bits
    set_rom_base(24'hFFFFFD);
    staged_items.delete();
    stage(OP_DATA, 32'hFFFF_FFFF);     // data while idle, ignored
    stage(OP_START, 32'h0);
    stage(OP_DATA, 32'd32);
    stage(OP_DATA, 32'hFFFF_FFFF);     // control
    stage(OP_DATA, 32'd2);             // length
    stage(OP_DATA, 32'hFFFF_FFFF);     // destination at the top of the space
    commit_staged(staged_items.size());
    // Sender holds off mid-boot until every result is back
    wait_drain();
    staged_items.delete();
    stage(OP_DATA, 32'hFFFF_FFFF);     // write at 0xFFFFFF
    stage(OP_DATA, 32'h0);             // destination wraps to 0
    stage(OP_DATA, 32'h0);             // zero length, done
    stage(OP_DATA, 32'h1234_5678);     // data after done, ignored
    stage(OP_START, 32'hFFFF_FFFF);
    stage(OP_DATA, 32'h0);             // invalid width
    stage(OP_START, 32'h0);
    stage(OP_DATA, 32'd16);
    stage(OP_DATA, 32'hFFFF_FFFF);     // control pieces, ORed unmasked
    stage(OP_DATA, 32'hFFFF_FFFF);
    stage(OP_DATA, 32'h0);             // zero length before any section
    stage(OP_DATA, 32'h0);
    stage(OP_START, 32'h0);
    stage(OP_DATA, 32'd8);
    stage(OP_DATA, 32'hA5);
    stage(OP_DATA, 32'h5A);
    stage(OP_START, 32'h0);            // restart in mid-word
    stage(OP_DATA, 32'd24);            // invalid width
    commit_staged(staged_items.size());
    wait_drain();

    // Random images at several ROM base settings
    set_rom_base(24'h000000);
    random_phase(RANDOM_ITEMS / 3);
    wait_drain();
    set_rom_base(24'hFFFFFF);
    random_phase(RANDOM_ITEMS / 3);
    wait_drain();
    set_rom_base(ADDR_W'($urandom));
    random_phase(RANDOM_ITEMS / 3);
    wait_drain();

    $display("Covered %0d input transactions (%0d ignored), 4 ROM base settings",
             n_accepted, n_ignored);
    $display("Checked %0d read requests, %0d memory writes, %0d boot completions",
             n_reads, n_writes, n_dones);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
